FILE: rtl/etbv_pkg.sv
// package: constants, types and helpers for the euler basis vector core
`timescale 1ns / 1ps
package etbv_pkg;
   localparam int AngleWidth = 16;
   localparam int CompWidth = 16;
   localparam int CordicSteps = 16;
   localparam int CordicWidth = 34;
   localparam int ZWidth = 20;
   localparam logic signed [AngleWidth:0] AngTwoPi = 17'sd51472;
   localparam logic signed [AngleWidth:0] AngPi = 17'sd25736;
   localparam logic signed [AngleWidth:0] AngHalfPi = 17'sd12868;
   localparam logic signed [CordicWidth-1:0] CordicGain = 34'sd652032874;
   localparam logic signed [CompWidth-1:0] OneQ14 = 16'sd16384;

   typedef logic signed [AngleWidth-1:0] angle_type;
   typedef logic signed [CompWidth-1:0] comp_type;

   typedef struct packed {
      angle_type angle_x;
      angle_type angle_y;
      angle_type angle_z;
   } req_type;

   typedef struct packed {
      comp_type right_x;
      comp_type right_y;
      comp_type right_z;
      comp_type up_x;
      comp_type up_y;
      comp_type up_z;
      comp_type forward_x;
      comp_type forward_y;
      comp_type forward_z;
   } rsp_type;

   function automatic logic signed [ZWidth-1:0] atan_q16(input logic [3:0] i);
      logic signed [ZWidth-1:0] v;
      case (i)
         4'd0: v = 20'sd51472;
         4'd1: v = 20'sd30386;
         4'd2: v = 20'sd16055;
         4'd3: v = 20'sd8150;
         4'd4: v = 20'sd4091;
         4'd5: v = 20'sd2047;
         4'd6: v = 20'sd1024;
         4'd7: v = 20'sd512;
         4'd8: v = 20'sd256;
         4'd9: v = 20'sd128;
         4'd10: v = 20'sd64;
         4'd11: v = 20'sd32;
         4'd12: v = 20'sd16;
         4'd13: v = 20'sd8;
         4'd14: v = 20'sd4;
         default: v = 20'sd2;
      endcase
      return v;
   endfunction

   // clamp to plus or minus one in q1.14
   function automatic comp_type sat_one(input logic signed [63:0] v);
      comp_type r;
      if (v > 64'sd16384) r = OneQ14;
      else if (v < -64'sd16384) r = -OneQ14;
      else r = v[CompWidth-1:0];
      return r;
   endfunction
endpackage

FILE: rtl/etbv_if.sv
// handshake channel interface carrying one payload
`timescale 1ns / 1ps
interface etbv_if #(parameter type payload_type = logic) (input logic clock);
   logic valid;
   logic ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/euler_to_basis_vectors_core.sv
// Euler angle to rotation basis core. One request is taken every clock cycle while the
// output is not stalled, and its result is offered from the last of 23 register
// stages: 1 reduction stage, 16 cordic stages, one rounding stage, and five product, sum,
// rounding and output stages. A stall freezes the whole pipeline, which is ready
// whenever its last stage is empty or being taken.
`timescale 1ns / 1ps
module euler_to_basis_vectors_core
   import etbv_pkg::*;
(
   input logic clock,
   input logic reset,
   etbv_if.sink req,
   etbv_if.source rsp
);
   localparam int Depth = CordicSteps + 7;
   typedef logic signed [CordicWidth-1:0] cx_type;
   typedef logic signed [ZWidth-1:0] z_type;

   logic [Depth-1:0] vld_ff;
   logic advance;
   assign advance = !vld_ff[Depth-1] || rsp.ready;
   assign req.ready = advance;

   // stage 0: range reduction
   cx_type x_ff [0:CordicSteps][3];
   cx_type y_ff [0:CordicSteps][3];
   z_type z_ff [0:CordicSteps][3];
   logic [2:0] neg_ff [0:CordicSteps];
   comp_type s_ff [3];
   comp_type c_ff [3];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[Depth-2:0], req.valid};
   end

   logic signed [AngleWidth:0] ang [3];
   assign ang[0] = (AngleWidth+1)'(req.data.angle_x);
   assign ang[1] = (AngleWidth+1)'(req.data.angle_y);
   assign ang[2] = (AngleWidth+1)'(req.data.angle_z);

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            logic signed [AngleWidth:0] a;
            logic n;
            a = ang[k];
            n = 1'b0;
            if (a > AngPi) a = a - AngTwoPi;
            else if (a < -AngPi) a = a + AngTwoPi;
            if (a > AngHalfPi) begin a = a - AngPi; n = 1'b1; end
            else if (a < -AngHalfPi) begin a = a + AngPi; n = 1'b1; end
            x_ff[0][k] <= CordicGain;
            y_ff[0][k] <= '0;
            z_ff[0][k] <= {a, 3'b000};
            neg_ff[0][k] <= n;
         end
      end
   end

   // cordic stages
   for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (advance) begin
            for (int k = 0; k < 3; k++) begin
               if (!z_ff[i][k][ZWidth-1]) begin
                  x_ff[i+1][k] <= x_ff[i][k] - (y_ff[i][k] >>> i);
                  y_ff[i+1][k] <= y_ff[i][k] + (x_ff[i][k] >>> i);
                  z_ff[i+1][k] <= z_ff[i][k] - atan_q16(4'(i));
               end else begin
                  x_ff[i+1][k] <= x_ff[i][k] + (y_ff[i][k] >>> i);
                  y_ff[i+1][k] <= y_ff[i][k] - (x_ff[i][k] >>> i);
                  z_ff[i+1][k] <= z_ff[i][k] + atan_q16(4'(i));
               end
               neg_ff[i+1][k] <= neg_ff[i][k];
            end
         end
      end
   end

   // rounding to q1.14
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            cx_type xv, yv;
            xv = neg_ff[CordicSteps][k] ? -x_ff[CordicSteps][k] : x_ff[CordicSteps][k];
            yv = neg_ff[CordicSteps][k] ? -y_ff[CordicSteps][k] : y_ff[CordicSteps][k];
            c_ff[k] <= sat_one(64'((xv + 34'sd32768) >>> 16));
            s_ff[k] <= sat_one(64'((yv + 34'sd32768) >>> 16));
         end
      end
   end

   // products: p1 two-factor, p2 three-factor, then sums
   logic signed [31:0] cycz_ff, cysz_ff, sxcy_ff, cxcy_ff, sxsy_ff, cxsy_ff;
   logic signed [31:0] cxsz_ff, cxcz_ff, sxsz_ff, sxcz_ff;
   comp_type sz_ff, cz_ff, nsy_ff;
   logic signed [47:0] t_ff [8];
   logic signed [47:0] u_ff [4];
   logic signed [31:0] p2_ff [4];
   comp_type r2_ff, r2b_ff;
   comp_type out_ff [9];
   logic signed [31:0] q_ff [4];

   always_ff @(posedge clock) begin
      if (advance) begin
         cycz_ff <= c_ff[1] * c_ff[2];
         cysz_ff <= c_ff[1] * s_ff[2];
         sxcy_ff <= s_ff[0] * c_ff[1];
         cxcy_ff <= c_ff[0] * c_ff[1];
         sxsy_ff <= s_ff[0] * s_ff[1];
         cxsy_ff <= c_ff[0] * s_ff[1];
         cxsz_ff <= c_ff[0] * s_ff[2];
         cxcz_ff <= c_ff[0] * c_ff[2];
         sxsz_ff <= s_ff[0] * s_ff[2];
         sxcz_ff <= s_ff[0] * c_ff[2];
         sz_ff <= s_ff[2];
         cz_ff <= c_ff[2];
         nsy_ff <= sat_one(-64'(s_ff[1]));
         // second stage: three-factor products
         t_ff[0] <= sxsy_ff * cz_ff;
         t_ff[1] <= 48'(cxsz_ff) <<< 14;
         t_ff[2] <= sxsy_ff * sz_ff;
         t_ff[3] <= 48'(cxcz_ff) <<< 14;
         t_ff[4] <= cxsy_ff * cz_ff;
         t_ff[5] <= 48'(sxsz_ff) <<< 14;
         t_ff[6] <= cxsy_ff * sz_ff;
         t_ff[7] <= 48'(sxcz_ff) <<< 14;
         q_ff[0] <= cycz_ff;
         q_ff[1] <= cysz_ff;
         q_ff[2] <= sxcy_ff;
         q_ff[3] <= cxcy_ff;
         r2_ff <= nsy_ff;
         // third stage: sums
         u_ff[0] <= t_ff[0] - t_ff[1];
         u_ff[1] <= t_ff[2] + t_ff[3];
         u_ff[2] <= t_ff[4] + t_ff[5];
         u_ff[3] <= t_ff[6] - t_ff[7];
         p2_ff <= q_ff;
         r2b_ff <= r2_ff;
         // fourth stage: rounding
         out_ff[0] <= sat_one(64'((p2_ff[0] + 32'sd8192) >>> 14));
         out_ff[1] <= sat_one(64'((p2_ff[1] + 32'sd8192) >>> 14));
         out_ff[2] <= r2b_ff;
         out_ff[3] <= sat_one(64'((u_ff[0] + 48'sd134217728) >>> 28));
         out_ff[4] <= sat_one(64'((u_ff[1] + 48'sd134217728) >>> 28));
         out_ff[5] <= sat_one(64'((p2_ff[2] + 32'sd8192) >>> 14));
         out_ff[6] <= sat_one(64'((u_ff[2] + 48'sd134217728) >>> 28));
         out_ff[7] <= sat_one(64'((u_ff[3] + 48'sd134217728) >>> 28));
         out_ff[8] <= sat_one(64'((p2_ff[3] + 32'sd8192) >>> 14));
         // fifth stage: output register
         rsp.data.right_x <= out_ff[0];
         rsp.data.right_y <= out_ff[1];
         rsp.data.right_z <= out_ff[2];
         rsp.data.up_x <= out_ff[3];
         rsp.data.up_y <= out_ff[4];
         rsp.data.up_z <= out_ff[5];
         rsp.data.forward_x <= out_ff[6];
         rsp.data.forward_y <= out_ff[7];
         rsp.data.forward_z <= out_ff[8];
      end
   end

   assign rsp.valid = vld_ff[Depth-1];

   // a held result stays put while the sink stalls
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result changed under stall");
   // a request accepted leaves a result in the pipeline
   a_track: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> vld_ff[0])
      else $error("accepted request lost");
   // the right_z output stays within plus or minus one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.data.right_z <= OneQ14 && rsp.data.right_z >= -OneQ14)
      else $error("component out of range");
endmodule
